// ===== hw/rtl/gdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date difference package
// Shared widths, status codes, the per-date result type and the month tables.
// ----------------------------------------------------------------------------
package gdd_pkg;

  // Field widths.
  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int StatW  = 2;
  localparam int GapW   = 22;

  // A serial day count for any 14-bit year fits in 23 bits.
  localparam int SerW = 23;

  // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
  // The result is exact for every 14-bit dividend.
  localparam int RecipW    = 13;
  localparam int RecipSh   = 19;
  localparam int ProdW     = YearW + RecipW;
  localparam int QuotW     = ProdW - RecipSh;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;

  localparam logic [8:0] DaysPerYear = 9'd365;
  localparam logic [6:0] Hundred     = 7'd100;

  localparam logic [GapW-1:0] GapMax = {GapW{1'b1}};

  // Status codes.
  localparam logic [StatW-1:0] STAT_OK         = 2'd0;
  localparam logic [StatW-1:0] STAT_BAD_FIRST  = 2'd1;
  localparam logic [StatW-1:0] STAT_BAD_SECOND = 2'd2;

  // Result of one date's conversion.
  typedef struct packed {
    logic            ok;
    logic [SerW-1:0] serial;
  } date_info_t;

  // Days in the months before month m of a common year.
  function automatic logic [8:0] month_cum(input logic [MonthW-1:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // Length of month m in a common year; zero for a month that does not exist.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] l;
    case (m)
      4'd2:                                 l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:              l = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
      4'd12:                                l = 5'd31;
      default:                              l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

// ===== hw/rtl/gdd_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date checker and serial day counter
// Three register stages: products, year terms and leap flag, then the day
// check and the final serial day count.
// ----------------------------------------------------------------------------
module gdd_serial import gdd_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic              clk,
  input  logic [DayW-1:0]   in_day,
  input  logic [MonthW-1:0] in_month,
  input  logic [YearW-1:0]  in_year,
  output date_info_t        out_info
);

  localparam logic [16:0] MaxYearW = 17'(MAX_YEAR);

  // Stage 1 registers.
  logic [DayW-1:0]  s1_day_r;
  logic [YearW-1:0] s1_year_r;
  logic [YearW-1:0] s1_prev_r;
  logic             s1_is_feb_r;
  logic             s1_past_feb_r;
  logic             s1_ok_r;
  logic [8:0]       s1_cum_r;
  logic [DayW-1:0]  s1_len_r;
  logic [ProdW-1:0] s1_yprod_r;
  logic [ProdW-1:0] s1_pprod_r;
  logic [SerW-1:0]  s1_p365_r;

  logic [YearW-1:0] prev_nxt;
  logic             month_ok_nxt;
  logic             year_ok_nxt;

  // Stage 1: decode the month, check the year range, start the divisions.
  always_comb begin
    prev_nxt     = in_year - YearW'(1);
    month_ok_nxt = in_month inside {[4'd1:4'd12]};
    year_ok_nxt  = (in_year != '0) && ({3'b000, in_year} <= MaxYearW);
  end

  always_ff @(posedge clk) begin
    s1_day_r      <= in_day;
    s1_year_r     <= in_year;
    s1_prev_r     <= prev_nxt;
    s1_is_feb_r   <= (in_month == 4'd2);
    s1_past_feb_r <= (in_month > 4'd2);
    s1_ok_r       <= month_ok_nxt && year_ok_nxt;
    s1_cum_r      <= month_cum(in_month);
    s1_len_r      <= month_len(in_month);
    s1_yprod_r    <= ProdW'(in_year) * ProdW'(Recip100);
    s1_pprod_r    <= ProdW'(prev_nxt) * ProdW'(Recip100);
    s1_p365_r     <= SerW'(prev_nxt) * SerW'(DaysPerYear);
  end

  // Stage 2 registers.
  logic [DayW-1:0] s2_day_r;
  logic            s2_is_feb_r;
  logic            s2_past_feb_r;
  logic            s2_ok_r;
  logic [8:0]      s2_cum_r;
  logic [DayW-1:0] s2_len_r;
  logic            s2_leap_r;
  logic [SerW-1:0] s2_base_r;

  logic [QuotW-1:0] yq_nxt;
  logic [QuotW-1:0] pq_nxt;
  logic [YearW-1:0] yrem_nxt;
  logic             leap_nxt;
  logic [SerW-1:0]  base_nxt;

  // Stage 2: leap rule from the year's quotient and remainder by 100, and
  // the day count of all whole years before this one.
  always_comb begin
    yq_nxt   = s1_yprod_r[ProdW-1:RecipSh];
    pq_nxt   = s1_pprod_r[ProdW-1:RecipSh];
    yrem_nxt = s1_year_r - (YearW'(yq_nxt) * YearW'(Hundred));
    leap_nxt = ((s1_year_r[1:0] == 2'b00) && (yrem_nxt != '0)) ||
               ((yrem_nxt == '0) && (yq_nxt[1:0] == 2'b00));
    base_nxt = s1_p365_r + SerW'(s1_prev_r >> 2) - SerW'(pq_nxt) + SerW'(pq_nxt >> 2);
  end

  always_ff @(posedge clk) begin
    s2_day_r      <= s1_day_r;
    s2_is_feb_r   <= s1_is_feb_r;
    s2_past_feb_r <= s1_past_feb_r;
    s2_ok_r       <= s1_ok_r;
    s2_cum_r      <= s1_cum_r;
    s2_len_r      <= s1_len_r;
    s2_leap_r     <= leap_nxt;
    s2_base_r     <= base_nxt;
  end

  // Stage 3 registers.
  date_info_t       s3_info_r;
  date_info_t       info_nxt;
  logic [DayW-1:0]  len_nxt;

  // Stage 3: check the day against the month length and finish the count.
  always_comb begin
    len_nxt         = s2_len_r + DayW'(s2_is_feb_r && s2_leap_r);
    info_nxt.ok     = s2_ok_r && (s2_day_r != '0) && (s2_day_r <= len_nxt);
    info_nxt.serial = s2_base_r + SerW'(s2_cum_r) + SerW'(s2_past_feb_r && s2_leap_r)
                      + SerW'(s2_day_r);
  end

  always_ff @(posedge clk) begin
    s3_info_r <= info_nxt;
  end

  assign out_info = s3_info_r;

endmodule

// ===== hw/rtl/gregorian_date_difference.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date difference
// Absolute number of days between two proleptic Gregorian dates.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is presented on the in_ ports with start high; it is taken
//   at every clock edge where start is high and busy is low. busy stays low,
//   so a new date pair may be issued in every cycle.
//   out_valid rises together with the result on out_status and out_day_gap.
//   Throughput is one transaction per cycle; each transaction passes through
//   the three stages of the date converter plus the output stage that forms
//   the absolute difference.
//   The first date is checked before the second; out_status names the first
//   invalid date and out_day_gap is then zero.
//   Reset (synchronous, active low) clears all valid bits, so no result is
//   reported for transactions in flight. The receiver cannot stall; every
//   result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module gregorian_date_difference import gdd_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DayW-1:0]   in_first_day,
  input  logic [MonthW-1:0] in_first_month,
  input  logic [YearW-1:0]  in_first_year,
  input  logic [DayW-1:0]   in_second_day,
  input  logic [MonthW-1:0] in_second_month,
  input  logic [YearW-1:0]  in_second_year,
  output logic              out_valid,
  output logic [StatW-1:0]  out_status,
  output logic [GapW-1:0]   out_day_gap
);

  date_info_t first_info;
  date_info_t second_info;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Both dates are converted in parallel.
  gdd_serial #(.MAX_YEAR(MAX_YEAR)) u_first (
    .clk      (clk),
    .in_day   (in_first_day),
    .in_month (in_first_month),
    .in_year  (in_first_year),
    .out_info (first_info)
  );

  gdd_serial #(.MAX_YEAR(MAX_YEAR)) u_second (
    .clk      (clk),
    .in_day   (in_second_day),
    .in_month (in_second_month),
    .in_year  (in_second_year),
    .out_info (second_info)
  );

  // Valid bits that travel with each transaction.
  logic [2:0] vld_r;
  logic [2:0] vld_nxt;
  logic       out_valid_r;

  assign vld_nxt = {vld_r[1:0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[2];
    end
  end

  // Output stage: status, absolute difference and saturation.
  logic [StatW-1:0] out_status_r;
  logic [GapW-1:0]  out_day_gap_r;
  logic [StatW-1:0] status_nxt;
  logic [GapW-1:0]  gap_nxt;
  logic [SerW-1:0]  diff_nxt;

  always_comb begin
    if (first_info.serial > second_info.serial) begin
      diff_nxt = first_info.serial - second_info.serial;
    end else begin
      diff_nxt = second_info.serial - first_info.serial;
    end
    if (!first_info.ok) begin
      status_nxt = STAT_BAD_FIRST;
      gap_nxt    = '0;
    end else if (!second_info.ok) begin
      status_nxt = STAT_BAD_SECOND;
      gap_nxt    = '0;
    end else begin
      status_nxt = STAT_OK;
      gap_nxt    = (diff_nxt > SerW'(GapMax)) ? GapMax : diff_nxt[GapW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= status_nxt;
    out_day_gap_r <= gap_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_day_gap = out_day_gap_r;

endmodule

// ===== tb/date_gap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date gap checker
// Watches the date-pair channel and the result channel of the Gregorian date
// difference block, predicts the status and day gap of every accepted
// transaction and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module date_gap_checker import gdd_pkg::*; #(
  parameter int MAX_YEAR = 9999
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [DayW-1:0]   in_first_day,
  input  logic [MonthW-1:0] in_first_month,
  input  logic [YearW-1:0]  in_first_year,
  input  logic [DayW-1:0]   in_second_day,
  input  logic [MonthW-1:0] in_second_month,
  input  logic [YearW-1:0]  in_second_year,
  input  logic              out_valid,
  input  logic [StatW-1:0]  out_status,
  input  logic [GapW-1:0]   out_day_gap,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [GapW-1:0]  gap;
  } gap_result_t;

  // Predicted results, oldest first.
  gap_result_t expected_gaps[$];

  int mismatches = 0;
  int pending    = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending;

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Length of month m (1 to 12) in year y.
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      2: begin
        n = is_leap(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        n = 30;
      end
      default: begin
        n = 31;
      end
    endcase
    return n;
  endfunction

  function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  // Days from the start of the era up to and including the given date.
  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = p * 365 + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
    return n + d;
  endfunction

  function automatic gap_result_t predict_gap(
    input int unsigned d1, input int unsigned m1, input int unsigned y1,
    input int unsigned d2, input int unsigned m2, input int unsigned y2
  );
    gap_result_t r;
    int unsigned a;
    int unsigned b;
    int unsigned g;
    r.gap = '0;
    if (!date_valid(d1, m1, y1)) begin
      r.status = STAT_BAD_FIRST;
    end else if (!date_valid(d2, m2, y2)) begin
      r.status = STAT_BAD_SECOND;
    end else begin
      r.status = STAT_OK;
      a = day_number(d1, m1, y1);
      b = day_number(d2, m2, y2);
      g = (a > b) ? a - b : b - a;
      r.gap = (g > GapMax) ? GapMax : g[GapW-1:0];
    end
    return r;
  endfunction

  // Record each accepted transaction and check each shown result.
  always @(posedge clk) begin
    gap_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      expected_gaps.delete();
    end else begin
      if (start && !busy) begin
        expected_gaps.push_back(predict_gap(in_first_day, in_first_month, in_first_year,
                                            in_second_day, in_second_month,
                                            in_second_year));
      end
      if (out_valid) begin
        if (expected_gaps.size() == 0) begin
          $display("%0t: unexpected result, got status %0d gap %0d",
                   $time, out_status, out_day_gap);
          errs++;
        end else begin
          exp_r = expected_gaps.pop_front();
          if (out_status !== exp_r.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp_r.status, out_status);
            errs++;
          end
          if (out_day_gap !== exp_r.gap) begin
            $display("%0t: day gap mismatch, expected %0d, got %0d",
                     $time, exp_r.gap, out_day_gap);
            errs++;
          end
        end
      end
    end
    mismatches <= mismatches + errs;
    pending    <= expected_gaps.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date difference testbench
// Drives directed and random date pairs with random idle gaps into the block;
// the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import gdd_pkg::*;

  localparam int MaxYear       = 9999;
  localparam int RandomItems   = 1400;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic [DayW-1:0]   in_first_day    = '0;
  logic [MonthW-1:0] in_first_month  = '0;
  logic [YearW-1:0]  in_first_year   = '0;
  logic [DayW-1:0]   in_second_day   = '0;
  logic [MonthW-1:0] in_second_month = '0;
  logic [YearW-1:0]  in_second_year  = '0;
  logic              out_valid;
  logic [StatW-1:0]  out_status;
  logic [GapW-1:0]   out_day_gap;
  int                fail_count;
  int                outstanding;
  int                idle_cycles = 0;

  gregorian_date_difference #(
    .MAX_YEAR(MaxYear)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_first_day   (in_first_day),
    .in_first_month (in_first_month),
    .in_first_year  (in_first_year),
    .in_second_day  (in_second_day),
    .in_second_month(in_second_month),
    .in_second_year (in_second_year),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_day_gap    (out_day_gap)
  );

  date_gap_checker #(
    .MAX_YEAR(MaxYear)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_first_day   (in_first_day),
    .in_first_month (in_first_month),
    .in_first_year  (in_first_year),
    .in_second_day  (in_second_day),
    .in_second_month(in_second_month),
    .in_second_year (in_second_year),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_day_gap    (out_day_gap),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one date pair and hold it until the block takes it.
  task automatic send_dates(
    input logic [DayW-1:0] d1, input logic [MonthW-1:0] m1, input logic [YearW-1:0] y1,
    input logic [DayW-1:0] d2, input logic [MonthW-1:0] m2, input logic [YearW-1:0] y2
  );
    in_first_day    <= d1;
    in_first_month  <= m1;
    in_first_year   <= y1;
    in_second_day   <= d2;
    in_second_month <= m2;
    in_second_year  <= y2;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly plausible dates, some with out-of-range years, some pure noise.
  task automatic pick_date(output logic [DayW-1:0] d, output logic [MonthW-1:0] m,
                           output logic [YearW-1:0] y);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: begin
          y = YearW'(100 * $urandom_range(1, 99));
        end
        1: begin
          y = YearW'(4 * $urandom_range(1, 2499));
        end
        2: begin
          y = YearW'($urandom_range(0, 1) ? $urandom_range(1, 20)
                                          : $urandom_range(9980, MaxYear));
        end
        default: begin
          y = YearW'($urandom_range(1, MaxYear));
        end
      endcase
      m = MonthW'($urandom_range(1, 12));
      d = DayW'(($urandom_range(0, 9) == 0) ? $urandom_range(29, 31)
                                             : $urandom_range(1, 28));
    end else if (r < 90) begin
      y = YearW'($urandom);
      m = MonthW'($urandom_range(1, 12));
      d = DayW'($urandom_range(1, 28));
    end else begin
      y = YearW'($urandom);
      m = MonthW'($urandom);
      d = DayW'($urandom);
    end
  endtask

  initial begin
    logic [DayW-1:0]   d1, d2;
    logic [MonthW-1:0] m1, m2;
    logic [YearW-1:0]  y1, y2;
    bit                burst;
    burst = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs: field extremes, leap rules and every invalid-date case.
    send_dates(5'd1,  4'd1,  14'd1,     5'd31, 4'd12, 14'd9999);
    send_dates(5'd31, 4'd12, 14'd9999,  5'd1,  4'd1,  14'd1);
    send_dates(5'd15, 4'd6,  14'd2024,  5'd15, 4'd6,  14'd2024);
    send_dates(5'd29, 4'd2,  14'd2000,  5'd1,  4'd3,  14'd2000);
    send_dates(5'd29, 4'd2,  14'd1900,  5'd1,  4'd3,  14'd1900);
    send_dates(5'd29, 4'd2,  14'd2004,  5'd28, 4'd2,  14'd2003);
    send_dates(5'd1,  4'd1,  14'd2000,  5'd29, 4'd2,  14'd2001);
    send_dates(5'd0,  4'd5,  14'd1999,  5'd3,  4'd5,  14'd1999);
    send_dates(5'd30, 4'd4,  14'd2021,  5'd31, 4'd4,  14'd2021);
    send_dates(5'd10, 4'd0,  14'd1500,  5'd10, 4'd7,  14'd1500);
    send_dates(5'd10, 4'd7,  14'd1500,  5'd10, 4'd13, 14'd1500);
    send_dates(5'd10, 4'd15, 14'd1500,  5'd0,  4'd14, 14'd1500);
    send_dates(5'd1,  4'd1,  14'd0,     5'd1,  4'd1,  14'd1);
    send_dates(5'd1,  4'd1,  14'd1,     5'd1,  4'd1,  14'd10000);
    send_dates(5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383);
    send_dates(5'd31, 4'd1,  14'd9999,  5'd1,  4'd12, 14'd1);
    send_dates(5'd0,  4'd0,  14'd0,     5'd0,  4'd0,  14'd0);
    send_dates(5'd1,  4'd3,  14'd2100,  5'd28, 4'd2,  14'd2100);
    send_dates(5'd31, 4'd12, 14'd1600,  5'd1,  4'd1,  14'd1601);
    send_dates(5'd30, 4'd4,  14'd2023,  5'd31, 4'd5,  14'd2023);
    send_dates(5'd29, 4'd2,  14'd2400,  5'd29, 4'd2,  14'd9996);
    drain_results();

    // Random pairs with random gaps and some gap-free stretches.
    for (int k = 0; k < RandomItems; k++) begin
      if (k % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      if (k == RandomItems / 2) drain_results();
      pick_date(d1, m1, y1);
      pick_date(d2, m2, y2);
      send_dates(d1, m1, y1, d2, m2, y2);
      if (!burst) idle_for(pick_gap());
    end
    start <= 1'b0;

    // Wait for the last results, then give the verdict.
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== gregorian_date_difference.f =====
hw/rtl/gdd_pkg.sv
hw/rtl/gdd_serial.sv
hw/rtl/gregorian_date_difference.sv
tb/date_gap_checker.sv
tb/testbench.sv
